### hw/rtl/dstq_pkg.sv
// Shared types and constants of the sorted deadline timer queue.
package dstq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ID_BITS   = 8;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned TID_W     = 8;
  localparam int unsigned DL_W      = 64;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned IN_W      = 144;
  localparam int unsigned OUT_W     = 88;

  localparam logic [DL_W-1:0] DL_MAX = {1'b0, {(DL_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic signed [DL_W-1:0] deadline;
  } entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic   eval_en;
    logic   apply_en;
    op_e    op;
    logic   ok;
    entry_t entry;
  } cmd_t;

endpackage

### hw/rtl/dstq_cell.sv
// One cell of the sorted chain: holds one timer and shifts with its neighbors.
module dstq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dstq_pkg::cmd_t   cmd_i,
  input  logic             occ_i,
  input  dstq_pkg::entry_t left_i,
  input  dstq_pkg::entry_t right_i,
  input  logic             left_later_i,
  input  logic             seen_i,
  output dstq_pkg::entry_t entry_o,
  output logic             later_o,
  output logic             seen_o
);

  dstq_pkg::entry_t entry_q, entry_d;
  logic later_q, later_d;
  logic match_q, match_d;

  // An empty cell counts as later than any new deadline, so the insert
  // point is the first held timer with a strictly later deadline.
  always_comb begin
    later_d = later_q;
    match_d = match_q;
    if (cmd_i.eval_en) begin
      later_d = !occ_i || ($signed(entry_q.deadline) > $signed(cmd_i.entry.deadline));
      match_d = occ_i && (entry_q.id == cmd_i.entry.id);
    end
  end

  assign seen_o = seen_i | match_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.apply_en && cmd_i.ok) begin
      case (cmd_i.op)
        dstq_pkg::OP_INSERT: begin
          if (later_q) begin
            entry_d = left_later_i ? left_i : cmd_i.entry;
          end
        end
        dstq_pkg::OP_REMOVE: begin
          if (seen_o) begin
            entry_d = right_i;
          end
        end
        dstq_pkg::OP_POP: begin
          entry_d = right_i;
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      later_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      later_q <= later_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign later_o = later_q;

endmodule

### hw/rtl/deadline_sorted_timer_queue.sv
// Top level of the sorted deadline timer queue: controller and chain of cells.
//
// This block keeps up to DEPTH timers sorted by signed 64-bit deadline in a
// row of cells, the earliest at the head; a new timer goes after any held
// timers with the same deadline. Each input word carries one operation
// (insert, remove by id, pop the head if its deadline is at or before now,
// or query) and yields exactly one result word. After the word is accepted
// the block runs a compare step, in which every cell compares its own timer
// against the key, a shift step, in which the id match runs down the chain
// and every cell shifts or holds, and a write step that loads the result
// register. The operands are taken in the idle step, and no new word is
// taken until the result of the word at work is loaded. A new word is
// accepted while a previous result still waits to be taken; the block then
// holds in its last step until the output register is free. The occupancy
// of the cells follows from the held count alone, so there is no clearing
// pass after reset.
module deadline_sorted_timer_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // Fields from bit 0: opcode[1:0], timer_id[9:2], deadline[73:10],
  // now[137:74], zero fill [143:138].
  input  logic [dstq_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // Fields from bit 0: status[1:0], id_present[2], popped_valid[3],
  // popped_id[11:4], next_deadline[75:12], entry_count[80:76],
  // zero fill [87:81].
  output logic [dstq_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned D = dstq_pkg::DEPTH;

  dstq_pkg::state_e state_q, state_d;

  // Operand registers of the word at work.
  dstq_pkg::op_e                  op_q;
  logic [dstq_pkg::ID_BITS-1:0]   id_q;
  logic [dstq_pkg::DL_W-1:0]      dl_q;
  logic [dstq_pkg::DL_W-1:0]      now_q;
  logic                           expire_q;

  logic [dstq_pkg::CNT_BITS-1:0]  count_q, count_d;

  // Result fields recorded during the shift step.
  dstq_pkg::status_e              status_q, status_d;
  logic                           present_q;
  logic                           popv_q, popv_d;
  logic [dstq_pkg::ID_BITS-1:0]   popid_q, popid_d;

  logic                           out_vld_q;
  logic [dstq_pkg::OUT_W-1:0]     out_data_q, out_data_d;

  dstq_pkg::cmd_t                 cmd;
  dstq_pkg::entry_t               entries [D];
  logic [D-1:0]                   later;
  logic [D-1:0]                   seen;
  logic [D-1:0]                   occ;
  logic                           present;
  logic                           full;
  logic                           expire_now;
  logic                           load_out;
  logic                           accept;

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign present = seen[D-1];
  assign full    = (count_q == dstq_pkg::CNT_BITS'(D));

  // Cells at or beyond the held count are empty.
  for (genvar i = 0; i < D; i++) begin : g_occ
    assign occ[i] = (dstq_pkg::CNT_BITS'(i) < count_q);
  end

  assign expire_now = occ[0] && !($signed(entries[0].deadline) > $signed(now_q));

  // Controller: sequences compare, shift and result load for each word.
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    load_out        = 1'b0;
    cmd.eval_en     = 1'b0;
    cmd.apply_en    = 1'b0;
    cmd.op          = op_q;
    cmd.ok          = 1'b0;
    cmd.entry.id    = id_q;
    cmd.entry.deadline = dl_q;
    count_d         = count_q;
    status_d        = status_q;
    popv_d          = popv_q;
    popid_d         = popid_q;

    case (state_q)
      dstq_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = dstq_pkg::S_EVAL;
        end
      end
      dstq_pkg::S_EVAL: begin
        cmd.eval_en = 1'b1;
        state_d     = dstq_pkg::S_APPLY;
      end
      dstq_pkg::S_APPLY: begin
        cmd.apply_en = 1'b1;
        status_d     = dstq_pkg::ST_OK;
        popv_d       = 1'b0;
        popid_d      = '0;
        case (op_q)
          dstq_pkg::OP_INSERT: begin
            // The duplicate check takes precedence over the full check.
            if (present) begin
              status_d = dstq_pkg::ST_DUPLICATE;
            end else if (full) begin
              status_d = dstq_pkg::ST_FULL;
            end else begin
              cmd.ok  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          dstq_pkg::OP_REMOVE: begin
            if (present) begin
              cmd.ok  = 1'b1;
              count_d = count_q - 1'b1;
            end else begin
              status_d = dstq_pkg::ST_NOT_FOUND;
            end
          end
          dstq_pkg::OP_POP: begin
            if (expire_q) begin
              cmd.ok  = 1'b1;
              count_d = count_q - 1'b1;
              popv_d  = 1'b1;
              popid_d = entries[0].id;
            end
          end
          default: begin
            cmd.ok = 1'b0;
          end
        endcase
        state_d = dstq_pkg::S_WRITE;
      end
      dstq_pkg::S_WRITE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = dstq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dstq_pkg::S_IDLE;
      end
    endcase
  end

  // Result word, taken from the head cell after the shift has settled.
  always_comb begin
    out_data_d          = '0;
    out_data_d[1:0]     = status_q;
    out_data_d[2]       = present_q;
    out_data_d[3]       = popv_q;
    out_data_d[11:4]    = dstq_pkg::TID_W'(popid_q);
    out_data_d[75:12]   = (count_q != '0) ? entries[0].deadline : dstq_pkg::DL_MAX;
    out_data_d[80:76]   = dstq_pkg::CNT_OUT_W'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dstq_pkg::S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= dstq_pkg::op_e'(s_axis_tdata_i[1:0]);
      id_q  <= s_axis_tdata_i[2 +: dstq_pkg::ID_BITS];
      dl_q  <= s_axis_tdata_i[73:10];
      now_q <= s_axis_tdata_i[137:74];
    end
    if (state_q == dstq_pkg::S_EVAL) begin
      expire_q <= expire_now;
    end
    if (state_q == dstq_pkg::S_APPLY) begin
      present_q <= present;
    end
    status_q <= status_d;
    popv_q   <= popv_d;
    popid_q  <= popid_d;
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  // The chain: each cell sees its left and right neighbor only. The head
  // has no left neighbor, so it takes the new timer when it is the insert
  // point.
  for (genvar i = 0; i < D; i++) begin : g_cell
    dstq_pkg::entry_t left_e, right_e;
    logic left_later, seen_in;
    if (i == 0) begin : g_head
      assign left_e     = '0;
      assign left_later = 1'b0;
      assign seen_in    = 1'b0;
    end else begin : g_body
      assign left_e     = entries[i-1];
      assign left_later = later[i-1];
      assign seen_in    = seen[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entries[i+1];
    end
    dstq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .left_i       (left_e),
      .right_i      (right_e),
      .left_later_i (left_later),
      .seen_i       (seen_in),
      .entry_o      (entries[i]),
      .later_o      (later[i]),
      .seen_o       (seen[i])
    );
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // The held count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dstq_pkg::CNT_BITS'(D))
    else $error("held count above depth");

  // A full report is only given when every cell is occupied.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[1:0] == dstq_pkg::ST_FULL) |->
      out_data_q[80:76] == dstq_pkg::CNT_OUT_W'(D))
    else $error("full status with free cells");

  // A duplicate report implies the id was seen in the chain.
  a_dup_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q[1:0] == dstq_pkg::ST_DUPLICATE) |-> out_data_q[2])
    else $error("duplicate status without presence");

  // A popped id is reported only with a pop, and a pop never fails.
  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_data_q[3]) |-> out_data_q[11:4] == '0)
    else $error("popped id without pop");

  // A successful operation moves the count by one in the shift step.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dstq_pkg::S_APPLY) |=> $stable(count_q) || $past(state_q) == dstq_pkg::S_APPLY)
    else $error("count changed outside shift step");

endmodule

### tb/tb_deadline_sorted_timer_queue.sv
// Self-checking testbench of the sorted deadline timer queue with a built-in timer predictor.
module tb_deadline_sorted_timer_queue;

  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned PHASE_WORDS  = 150;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic signed [dstq_pkg::DL_W-1:0] DL_MIN = {1'b1, {(dstq_pkg::DL_W-1){1'b0}}};

  // One result word, unpacked into its fields.
  typedef struct {
    dstq_pkg::status_e                status;
    logic                             id_present;
    logic                             popped_valid;
    logic [dstq_pkg::TID_W-1:0]       popped_id;
    logic signed [dstq_pkg::DL_W-1:0] next_deadline;
    logic [dstq_pkg::CNT_OUT_W-1:0]   entry_count;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // Fields from bit 0: opcode, timer_id, deadline, now, zero fill.
  logic [dstq_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // Fields from bit 0: status, id_present, popped_valid, popped_id,
  // next_deadline, entry_count, zero fill.
  logic [dstq_pkg::OUT_W-1:0] m_axis_tdata;

  deadline_sorted_timer_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predicted contents of the queue, earliest deadline first.
  logic signed [dstq_pkg::DL_W-1:0] timer_deadlines [dstq_pkg::DEPTH];
  logic [dstq_pkg::TID_W-1:0]       timer_ids [dstq_pkg::DEPTH];
  int                               timers_held = 0;

  logic [dstq_pkg::IN_W-1:0] pending_words [$];
  timer_result_t             expected_results [$];
  int                        total_words = 0;
  int                        words_accepted = 0;
  int                        words_sent = 0;
  int                        mismatches = 0;
  int                        cycles = 0;
  int                        sender_pct;
  int                        receiver_pct;

  function automatic logic [dstq_pkg::IN_W-1:0] pack_word(
      dstq_pkg::op_e op, logic [dstq_pkg::TID_W-1:0] id,
      logic [dstq_pkg::DL_W-1:0] dl, logic [dstq_pkg::DL_W-1:0] now_v);
    return {{(dstq_pkg::IN_W-138){1'b0}}, now_v, dl, id, op};
  endfunction

  task automatic drop_timer(input int at);
    for (int i = at; i + 1 < timers_held; i++) begin
      timer_deadlines[i] = timer_deadlines[i+1];
      timer_ids[i]       = timer_ids[i+1];
    end
    timers_held--;
  endtask

  // Applies one accepted command word to the predicted queue and records
  // the result word it must produce.
  task automatic advance_timers(input logic [dstq_pkg::IN_W-1:0] word);
    dstq_pkg::op_e                    op;
    logic [dstq_pkg::TID_W-1:0]       id;
    logic signed [dstq_pkg::DL_W-1:0] dl;
    logic signed [dstq_pkg::DL_W-1:0] now_t;
    timer_result_t                    r;
    int                               where;
    int                               pos;
    op    = dstq_pkg::op_e'(word[1:0]);
    id    = word[9:2] & dstq_pkg::TID_W'((1 << dstq_pkg::ID_BITS) - 1);
    dl    = word[73:10];
    now_t = word[137:74];
    r.status       = dstq_pkg::ST_OK;
    r.popped_valid = 1'b0;
    r.popped_id    = '0;
    where = -1;
    for (int i = 0; i < timers_held; i++) begin
      if (where < 0 && timer_ids[i] == id) where = i;
    end
    r.id_present = (where >= 0);
    case (op)
      dstq_pkg::OP_INSERT: begin
        if (where >= 0) begin
          r.status = dstq_pkg::ST_DUPLICATE;
        end else if (timers_held >= dstq_pkg::DEPTH) begin
          r.status = dstq_pkg::ST_FULL;
        end else begin
          // Equal deadlines keep arrival order: skip every held timer not later.
          pos = 0;
          while (pos < timers_held && !(timer_deadlines[pos] > dl)) pos++;
          for (int i = timers_held; i > pos; i--) begin
            timer_deadlines[i] = timer_deadlines[i-1];
            timer_ids[i]       = timer_ids[i-1];
          end
          timer_deadlines[pos] = dl;
          timer_ids[pos]       = id;
          timers_held++;
        end
      end
      dstq_pkg::OP_REMOVE: begin
        if (where >= 0) drop_timer(where);
        else r.status = dstq_pkg::ST_NOT_FOUND;
      end
      dstq_pkg::OP_POP: begin
        if (timers_held > 0 && !(timer_deadlines[0] > now_t)) begin
          r.popped_valid = 1'b1;
          r.popped_id    = timer_ids[0];
          drop_timer(0);
        end
      end
      default: begin
      end
    endcase
    r.next_deadline = (timers_held > 0) ? timer_deadlines[0] : dstq_pkg::DL_MAX;
    r.entry_count   = dstq_pkg::CNT_OUT_W'(timers_held);
    expected_results.push_back(r);
  endtask

  // Idle phases rotate every PHASE_WORDS words: none, sender, receiver, both.
  always_comb begin
    case ((words_sent / PHASE_WORDS) % 4)
      0: begin sender_pct = 0;  receiver_pct = 0;  end
      1: begin sender_pct = 49; receiver_pct = 0;  end
      2: begin sender_pct = 0;  receiver_pct = 49; end
      default: begin sender_pct = 35; receiver_pct = 35; end
    endcase
  end

  // Command driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_timers(s_axis_tdata);
        words_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words.pop_front();
          words_sent    <= words_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    timer_result_t seen;
    timer_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status        = dstq_pkg::status_e'(m_axis_tdata[1:0]);
        seen.id_present    = m_axis_tdata[2];
        seen.popped_valid  = m_axis_tdata[3];
        seen.popped_id     = m_axis_tdata[11:4];
        seen.next_deadline = m_axis_tdata[75:12];
        seen.entry_count   = m_axis_tdata[80:76];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing outstanding: %h", $time, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status || seen.id_present !== want.id_present ||
              seen.popped_valid !== want.popped_valid || seen.popped_id !== want.popped_id ||
              seen.next_deadline !== want.next_deadline ||
              seen.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected st=%0d pres=%0b pop=%0b id=%0d next=%0d cnt=%0d",
                       $time, want.status, want.id_present, want.popped_valid,
                       want.popped_id, want.next_deadline, want.entry_count);
              $display("          actual   st=%0d pres=%0b pop=%0b id=%0d next=%0d cnt=%0d",
                       seen.status, seen.id_present, seen.popped_valid,
                       seen.popped_id, seen.next_deadline, seen.entry_count);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dstq_pkg::op_e              op;
    logic [dstq_pkg::TID_W-1:0] id;
    logic [dstq_pkg::DL_W-1:0]  dl;
    logic [dstq_pkg::DL_W-1:0]  nw;
    int                         roll;
    bit                         filling;

    // Directed: empty queue, extremes, duplicates, ties, expiry edges, full.
    pending_words.push_back(pack_word(dstq_pkg::OP_QUERY,  8'd0,   '0, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_POP,    8'd0,   '0, dstq_pkg::DL_MAX));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd255, dstq_pkg::DL_MAX, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd0,   DL_MIN, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd0,   64'd0, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd10,  64'd5, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd11,  64'd5, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_POP,    8'd0,   '0, DL_MIN));
    pending_words.push_back(pack_word(dstq_pkg::OP_POP,    8'd0,   '0, 64'd4));
    pending_words.push_back(pack_word(dstq_pkg::OP_POP,    8'd0,   '0, 64'd5));
    pending_words.push_back(pack_word(dstq_pkg::OP_REMOVE, 8'd11,  '0, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_REMOVE, 8'd11,  '0, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_QUERY,  8'd255, '0, '0));
    for (int k = 0; k < 15; k++)
      pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, dstq_pkg::TID_W'(100 + k),
                                        {$urandom, $urandom}, '0));
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd200, 64'd1, '0));
    // The duplicate check wins over the full check.
    pending_words.push_back(pack_word(dstq_pkg::OP_INSERT, 8'd255, 64'd1, '0));

    // Random: alternating fill and drain stretches over a small id pool so
    // that removes hit, the queue fills up, and deadlines often tie.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      filling = ((n / 100) % 2 == 0);
      roll = $urandom_range(99);
      if (roll < (filling ? 55 : 25))      op = dstq_pkg::OP_INSERT;
      else if (roll < (filling ? 70 : 55)) op = dstq_pkg::OP_REMOVE;
      else if (roll < (filling ? 85 : 90)) op = dstq_pkg::OP_POP;
      else                                 op = dstq_pkg::OP_QUERY;
      id = ($urandom_range(99) < 75) ? dstq_pkg::TID_W'($urandom_range(23))
                                     : dstq_pkg::TID_W'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 50)      dl = dstq_pkg::DL_W'($signed($urandom_range(16)) - 8);
      else if (roll < 85) dl = {$urandom, $urandom};
      else                dl = ($urandom_range(1) != 0) ? dstq_pkg::DL_MAX - $urandom_range(1)
                                                         : DL_MIN + $urandom_range(1);
      roll = $urandom_range(99);
      if (roll < 40)      nw = dstq_pkg::DL_W'($signed($urandom_range(16)) - 8);
      else if (roll < 80) nw = {$urandom, $urandom};
      else                nw = ($urandom_range(1) != 0) ? dstq_pkg::DL_MAX : DL_MIN;
      pending_words.push_back(pack_word(op, id, dl, nw));
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != total_words || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
